// ----- sv/mi_pkg.sv -----
package mi_pkg;

    // Default operand width
    localparam int VALUE_BITS_DEF = 32;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;      // take a new item, seed the Euclid pairs
        logic div_step;  // one quotient bit of r / newr
        logic update;    // rotate remainder and coefficient pairs
        logic finish;    // form the result and load the output register
    } mi_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic nr_zero;   // newr is zero
        logic rem_zero;  // remainder of the running division is zero
    } mi_stat_t;

endpackage

// ----- sv/modular_inverse_top.sv -----
// Modular inverse by the extended Euclidean algorithm.
// Input channel: in_valid / in_stall with modulus and value. An item is taken
// at a clock edge where in_valid is high and in_stall is low.
// Output channel: out_valid / out_stall with inverse and has_inverse, one
// result item per input item. has_inverse is low and inverse is zero when the
// gcd of modulus and value is not one; otherwise inverse is the coefficient
// with the modulus added once if it was negative.
// Timing: one item at a time. In each Euclid step a bit-serial restoring
// divider gives one quotient bit per cycle while q * newt is accumulated
// alongside, then an update step rotates the pairs. For 32-bit operands
// there are at most 46 steps, and none when value is zero. The next item
// can be taken in the cycle after the result loads.
// in_stall stays high from acceptance until the result is moved into the
// output register, so a new item can be taken while the last result waits.
// If the receiver stalls with a result still held, the finished item waits in
// the datapath until the output register frees up.
// Reset clears the controller and the output valid; no clearing pass.
module modular_inverse_top #(
    parameter int VALUE_BITS = mi_pkg::VALUE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [VALUE_BITS-1:0] modulus,
    input  logic [VALUE_BITS-1:0] value,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [VALUE_BITS-1:0] inverse,
    output logic                  has_inverse
);
    import mi_pkg::*;

    mi_cmd_t  cmd;
    mi_stat_t stat;

    mi_ctrl #(
        .VALUE_BITS (VALUE_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    mi_dpath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dpath (
        .clk         (clk),
        .modulus     (modulus),
        .value       (value),
        .cmd         (cmd),
        .stat        (stat),
        .inverse     (inverse),
        .has_inverse (has_inverse)
    );

    // an accepted item keeps the input side closed in the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after accepting an item");

    // a new result only appears out of a busy cycle
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a busy cycle");

    // no inverse means a zero coefficient
    a_zero_when_none: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !has_inverse) |-> (inverse == '0))
        else $error("nonzero inverse flagged as absent");

    // the datapath is never commanded twice in one cycle
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("conflicting datapath commands");

endmodule

// ----- sv/mi_ctrl.sv -----
module mi_ctrl #(
    parameter int VALUE_BITS = mi_pkg::VALUE_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  logic            out_stall,
    input  mi_pkg::mi_stat_t stat,
    output mi_pkg::mi_cmd_t  cmd
);
    import mi_pkg::*;

    localparam int CW = $clog2(VALUE_BITS);
    localparam logic [CW-1:0] LAST_BIT = CW'(VALUE_BITS - 1);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_CHK  = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_UPD  = 5'b01000,
        ST_FIN  = 5'b10000
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          out_valid_reg, out_valid_next;
    logic          out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHK;
                end
            end
            ST_CHK:
            begin
                count_next = '0;
                state_next = stat.nr_zero ? ST_FIN : ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (count_reg == LAST_BIT)
                begin
                    state_next = ST_UPD;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            ST_UPD:
            begin
                cmd.update = 1'b1;
                count_next = '0;
                state_next = stat.rem_zero ? ST_FIN : ST_DIV;
            end
            ST_FIN:
            begin
                // hold the result until the output register is free
                if (out_free)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- sv/mi_dpath.sv -----
module mi_dpath #(
    parameter int VALUE_BITS = mi_pkg::VALUE_BITS_DEF
) (
    input  logic                  clk,
    input  logic [VALUE_BITS-1:0] modulus,
    input  logic [VALUE_BITS-1:0] value,
    input  mi_pkg::mi_cmd_t       cmd,
    output mi_pkg::mi_stat_t      stat,
    output logic [VALUE_BITS-1:0] inverse,
    output logic                  has_inverse
);
    import mi_pkg::*;

    localparam int W = VALUE_BITS;

    logic [W-1:0] n_reg, n_next;
    logic [W-1:0] r_reg, r_next;
    logic [W-1:0] nr_reg, nr_next;
    logic [W-1:0] tm_reg, tm_next;
    logic [W-1:0] ntm_reg, ntm_next;
    logic         tneg_reg, tneg_next;
    logic         ntneg_reg, ntneg_next;
    logic [W-1:0] dvd_reg, dvd_next;
    logic [W-1:0] rem_reg, rem_next;
    logic [W-1:0] acc_reg, acc_next;
    logic [W-1:0] inv_reg, inv_next;
    logic         has_reg, has_next;

    logic [W:0]   partial;
    logic [W:0]   diff;
    logic         qbit;
    logic         gcd_one;
    logic [W-1:0] coef;

    // restoring division, one quotient bit per cycle; q * newt built by Horner
    assign partial = {rem_reg, dvd_reg[W-1]};
    assign diff    = partial - {1'b0, nr_reg};
    assign qbit    = !diff[W];

    assign gcd_one = (r_reg == W'(1));
    assign coef    = (tneg_reg && (tm_reg != '0)) ? (n_reg - tm_reg) : tm_reg;

    assign stat.nr_zero  = (nr_reg == '0);
    assign stat.rem_zero = (rem_reg == '0);

    always_comb
    begin
        n_next     = n_reg;
        r_next     = r_reg;
        nr_next    = nr_reg;
        tm_next    = tm_reg;
        ntm_next   = ntm_reg;
        tneg_next  = tneg_reg;
        ntneg_next = ntneg_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        acc_next   = acc_reg;
        inv_next   = inv_reg;
        has_next   = has_reg;
        if (cmd.load)
        begin
            n_next     = modulus;
            r_next     = modulus;
            nr_next    = value;
            dvd_next   = modulus;
            tm_next    = '0;
            ntm_next   = W'(1);
            tneg_next  = 1'b0;
            ntneg_next = 1'b0;
            rem_next   = '0;
            acc_next   = '0;
        end
        else if (cmd.div_step)
        begin
            rem_next = qbit ? diff[W-1:0] : partial[W-1:0];
            dvd_next = {dvd_reg[W-2:0], 1'b0};
            acc_next = {acc_reg[W-2:0], 1'b0} + (qbit ? ntm_reg : '0);
        end
        else if (cmd.update)
        begin
            r_next     = nr_reg;
            nr_next    = rem_reg;
            dvd_next   = nr_reg;
            tm_next    = ntm_reg;
            tneg_next  = ntneg_reg;
            ntm_next   = tm_reg + acc_reg;
            ntneg_next = !ntneg_reg;
            rem_next   = '0;
            acc_next   = '0;
        end
        else if (cmd.finish)
        begin
            inv_next = gcd_one ? coef : '0;
            has_next = gcd_one;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        r_reg     <= r_next;
        nr_reg    <= nr_next;
        tm_reg    <= tm_next;
        ntm_reg   <= ntm_next;
        tneg_reg  <= tneg_next;
        ntneg_reg <= ntneg_next;
        dvd_reg   <= dvd_next;
        rem_reg   <= rem_next;
        acc_reg   <= acc_next;
        inv_reg   <= inv_next;
        has_reg   <= has_next;
    end

    assign inverse     = inv_reg;
    assign has_inverse = has_reg;

endmodule

// ----- verif/tb_modular_inverse_top.sv -----
module tb_modular_inverse_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VALUE_BITS  = mi_pkg::VALUE_BITS_DEF;
    localparam int IDLE_PCT    = 20;
    // Worst case is 46 Euclid steps.
    localparam int TAIL_CYCLES = 2000;
    // Roughly 421 items at worst-case latency plus stalls, taken about six times over.
    localparam int CYCLE_LIMIT = 4000000;

    typedef logic [VALUE_BITS-1:0] word_t;

    typedef struct {
        word_t modulus;
        word_t value;
    } query_t;

    typedef struct {
        word_t inverse;
        logic  has_inverse;
    } result_t;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  in_valid = 1'b0;
    logic  in_stall;
    word_t modulus = '0;
    word_t value = '0;
    logic  out_valid;
    logic  out_stall = 1'b0;
    word_t inverse;
    logic  has_inverse;

    // Items waiting to be driven, and inverses predicted for accepted items.
    query_t  operand_queue[$];
    result_t inverse_queue[$];

    logic in_fire = 1'b0;   // input handshake seen at the last rising edge
    logic no_idle = 1'b0;   // suppress all idling on both sides

    int cycle_count    = 0;
    int accepted_items = 0;
    int results_seen   = 0;
    int no_inverse_cnt = 0;
    int mismatch_count = 0;

    modular_inverse_top #(
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .modulus    (modulus),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .inverse    (inverse),
        .has_inverse(has_inverse)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Extended Euclid on magnitudes plus a sign bit. Coefficient arithmetic wraps
    // at VALUE_BITS; the final coefficient gets the modulus added once if negative.
    function automatic result_t compute_inverse(word_t n, word_t b);
        word_t   r;
        word_t   nr;
        word_t   quot;
        word_t   rem;
        word_t   tm;
        word_t   ntm;
        word_t   mag;
        logic    tneg;
        logic    ntneg;
        result_t res;
        r     = n;
        nr    = b;
        tm    = '0;
        ntm   = 1;
        tneg  = 1'b0;
        ntneg = 1'b0;
        while (nr != 0)
        begin
            quot  = r / nr;
            rem   = r - quot * nr;
            mag   = tm + quot * ntm;
            r     = nr;
            nr    = rem;
            tm    = ntm;
            tneg  = ntneg;
            ntm   = mag;
            ntneg = !ntneg;
        end
        if (r != 1)
        begin
            res.inverse     = '0;
            res.has_inverse = 1'b0;
        end
        else
        begin
            res.inverse     = (tneg && tm != 0) ? n - tm : tm;
            res.has_inverse = 1'b1;
        end
        return res;
    endfunction

    function automatic word_t edge_operand();
        case ($urandom_range(5))
            0:       return '0;
            1:       return word_t'(1);
            2:       return word_t'(2);
            3:       return '1;
            4:       return '1 - 1;
            default: return word_t'(1) << (VALUE_BITS - 1);
        endcase
    endfunction

    // Mix of operand shapes: half full-width random pairs, plus small moduli,
    // shared factors (no inverse), value above modulus, a prime modulus and edges.
    function automatic query_t random_query();
        query_t qry;
        int     pick;
        word_t  factor;
        pick = $urandom_range(99);
        if (pick < 50)
        begin
            qry.modulus = $urandom;
            qry.value   = $urandom;
        end
        else if (pick < 65)
        begin
            qry.modulus = $urandom_range(1, 200);
            qry.value   = $urandom_range(0, 400);
        end
        else if (pick < 80)
        begin
            factor      = $urandom_range(2, 60);
            qry.modulus = factor * word_t'($urandom_range(1, 1 << 25));
            qry.value   = factor * word_t'($urandom_range(0, 1 << 25));
        end
        else if (pick < 90)
        begin
            qry.modulus = word_t'($urandom) >> $urandom_range(1, 31);
            qry.value   = $urandom | (word_t'(1) << (VALUE_BITS - 1));
        end
        else if (pick < 95)
        begin
            qry.modulus = 32'd4294967291;
            qry.value   = $urandom;
        end
        else
        begin
            qry.modulus = edge_operand();
            qry.value   = ($urandom_range(1)) ? edge_operand() : word_t'($urandom);
        end
        return qry;
    endfunction

    task automatic add_query(word_t n, word_t b);
        query_t qry;
        qry.modulus = n;
        qry.value   = b;
        operand_queue.push_back(qry);
    endtask

    task automatic add_random(int count);
        repeat (count) operand_queue.push_back(random_query());
    endtask

    // Hold until every queued item is accepted and every result has come back.
    // Look just after the falling edge so the driver's update has landed.
    // Return on a rising edge so the next fill never races the driver.
    task automatic wait_for_drain();
        @(negedge clk);
        #1;
        while (operand_queue.size() != 0 || in_valid || inverse_queue.size() != 0)
        begin
            @(negedge clk);
            #1;
        end
        @(posedge clk);
    endtask

    // Driver: change inputs on the falling edge. Keep the payload steady while
    // an item is offered and not yet taken; otherwise offer the next item or idle.
    always @(negedge clk)
    begin
        query_t next_query;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            out_stall <= 1'b0;
        end
        else
        begin
            out_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
            if (!in_valid || in_fire)
            begin
                if (operand_queue.size() != 0 &&
                    (no_idle || $urandom_range(99) >= IDLE_PCT))
                begin
                    next_query = operand_queue.pop_front();
                    modulus  <= next_query.modulus;
                    value    <= next_query.value;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: sample both handshakes on the rising edge. Predict each accepted
    // item and compare each delivered result against the oldest prediction.
    always @(posedge clk)
    begin
        result_t want;
        cycle_count = cycle_count + 1;
        in_fire <= in_valid && !in_stall;

        if (rst_n && out_valid && !out_stall)
        begin
            results_seen = results_seen + 1;
            if (inverse_queue.size() == 0)
            begin
                $error("unexpected result: inverse %h has_inverse %b", inverse, has_inverse);
                mismatch_count = mismatch_count + 1;
            end
            else
            begin
                want = inverse_queue.pop_front();
                if (!want.has_inverse)
                    no_inverse_cnt = no_inverse_cnt + 1;
                if (inverse !== want.inverse)
                begin
                    $error("inverse mismatch: expected %h, actual %h", want.inverse, inverse);
                    mismatch_count = mismatch_count + 1;
                end
                if (has_inverse !== want.has_inverse)
                begin
                    $error("has_inverse mismatch: expected %b, actual %b",
                           want.has_inverse, has_inverse);
                    mismatch_count = mismatch_count + 1;
                end
            end
        end

        if (rst_n && in_valid && !in_stall)
        begin
            inverse_queue.push_back(compute_inverse(modulus, value));
            accepted_items = accepted_items + 1;
        end

        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        // Hold reset, then release it on a falling edge.
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners: value zero, modulus one and zero, gcd above one,
        // value above modulus, all-ones operands and the Fibonacci worst case.
        add_query(32'd1, 32'd0);
        add_query(32'd1, 32'd1);
        add_query(32'd1, 32'hFFFF_FFFF);
        add_query(32'd0, 32'd0);
        add_query(32'd0, 32'd1);
        add_query(32'd0, 32'hFFFF_FFFF);
        add_query(32'd0, 32'd12);
        add_query(32'd7, 32'd0);
        add_query(32'd7, 32'd3);
        add_query(32'd3, 32'd7);
        add_query(32'd12, 32'd8);
        add_query(32'd2, 32'd1);
        add_query(32'hFFFF_FFFF, 32'd1);
        add_query(32'hFFFF_FFFF, 32'hFFFF_FFFE);
        add_query(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_query(32'd4294967291, 32'd2);
        add_query(32'd2971215073, 32'd1836311903);
        add_query(32'd1836311903, 32'd2971215073);
        add_query(32'h8000_0000, 32'h7FFF_FFFF);
        add_query(32'hAAAA_AAAA, 32'h5555_5555);
        add_query(32'h5555_5555, 32'hAAAA_AAAA);
        wait_for_drain();

        // Random phase with idling on both sides; the sender pauses until
        // everything has drained between batches.
        add_random(150);
        wait_for_drain();

        // Gap-free stretch: no idle cycles, no output stalls.
        no_idle = 1'b1;
        add_random(100);
        wait_for_drain();
        no_idle = 1'b0;

        add_random(150);
        wait_for_drain();

        // Allow a stray late result to show up before the verdict.
        repeat (TAIL_CYCLES) @(posedge clk);
        @(negedge clk);

        $display("Covered %0d items and %0d results, %0d of them without an inverse.",
                 accepted_items, results_seen, no_inverse_cnt);
        $display("Corners included zero operands, unit and zero moduli, the Fibonacci pair, %s",
                 "idle and stall gaps and a gap-free stretch.");
        if (mismatch_count == 0 && inverse_queue.size() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            if (inverse_queue.size() != 0)
                $error("%0d expected results never arrived", inverse_queue.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/mi_pkg.sv
sv/mi_ctrl.sv
sv/mi_dpath.sv
sv/modular_inverse_top.sv
verif/tb_modular_inverse_top.sv
